>>> rtl/afcr_pkg.sv
// Shared constants for the aspect-ratio fit block.
// No dependencies; compiled first.
package afcr_pkg;

  // Default coordinate width; the fraction position does not affect the datapath.
  localparam int unsigned CoordBits = 24;

endpackage

>>> rtl/afcr_if.sv
// Valid/ready channel interfaces for the aspect-ratio fit block.
// Depends on afcr_pkg for the default coordinate width.
interface afcr_in_if #(
  parameter int unsigned COORD_BITS = afcr_pkg::CoordBits
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] target_x;
  logic signed [COORD_BITS-1:0] target_y;
  logic        [COORD_BITS-1:0] target_w;
  logic        [COORD_BITS-1:0] target_h;
  logic        [COORD_BITS-1:0] src_w;
  logic        [COORD_BITS-1:0] src_h;
  logic                         horizontal_first;

  modport source (
    output valid, target_x, target_y, target_w, target_h, src_w, src_h, horizontal_first,
    input  ready
  );
  modport sink (
    input  valid, target_x, target_y, target_w, target_h, src_w, src_h, horizontal_first,
    output ready
  );
endinterface

interface afcr_out_if #(
  parameter int unsigned COORD_BITS = afcr_pkg::CoordBits
) ();
  logic                       valid;
  logic                       ready;
  logic signed [COORD_BITS:0] out_x;
  logic signed [COORD_BITS:0] out_y;
  logic      [COORD_BITS-1:0] out_w;
  logic      [COORD_BITS-1:0] out_h;
  logic                       degenerate;

  modport source (
    output valid, out_x, out_y, out_w, out_h, degenerate,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_w, out_h, degenerate,
    output ready
  );
endinterface

>>> rtl/aspect_fit_center_rect.sv
// Aspect-ratio fit (letterbox): scales a source size into a target rectangle and centres it.
// Depends on afcr_pkg and the channel interfaces in afcr_if.sv.
//
// Usage:
//   in_i  : one transaction per request: target rectangle, source size, fit-order bit.
//   out_o : one transaction per request: fitted position, size and a degenerate flag
//           (set when a source dimension is zero; size is then zero at the target centre).
// Pipeline: a multiply stage (two COORD_BITS x COORD_BITS products), a compare/select
//   stage, COORD_BITS restoring-division stages (one quotient bit each) and a centring
//   stage that is also the output register.
// Throughput: one transaction per cycle while no stall holds the input (see Stall below);
//   the division pipeline sets the latency.
// Reset: all stage valid bits clear; the block is ready straight after reset.
// Stall: while out_o.ready is low the output holds. Stages behind it keep advancing into
//   empty slots, so in_i.ready only drops once every stage holds a transaction.
module aspect_fit_center_rect #(
  parameter int unsigned COORD_BITS = afcr_pkg::CoordBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  afcr_in_if.sink    in_i,
  afcr_out_if.source out_o
);
  import afcr_pkg::*;

  localparam int unsigned C      = COORD_BITS;
  localparam int unsigned W2     = 2 * C;
  localparam int unsigned NSt    = C + 3;
  localparam int unsigned StMul  = 0;
  localparam int unsigned StSel  = 1;
  localparam int unsigned StDiv0 = 2;
  localparam int unsigned StOut  = NSt - 1;

  typedef struct packed {
    logic [C-1:0] tx;
    logic [C-1:0] ty;
    logic [C-1:0] tw;
    logic [C-1:0] th;
    logic         deg;
  } cmn_t;

  typedef struct packed {
    cmn_t          cmn;
    logic          uw;
    logic [C-1:0]  d;
    logic [W2-1:0] work;
  } dv_t;

  // One restoring-division step: remainder in the upper half, quotient shifts into the lower.
  function automatic logic [W2-1:0] div_step(input logic [W2-1:0] w, input logic [C-1:0] d);
    logic [C:0] r;
    logic [C:0] t;
    logic       q;
    r = {w[W2-1:C], w[C-1]};
    t = r - {1'b0, d};
    q = (r >= {1'b0, d});
    if (q) begin
      r = t;
    end
    return {r[C-1:0], w[C-2:0], q};
  endfunction

  logic [NSt-1:0] vld_q;
  logic [NSt-1:0] vin;
  logic [NSt-1:0] en;

  // Stage advances when downstream takes, or some stage at or after it is empty.
  assign vin = {vld_q[NSt-2:0], in_i.valid};
  for (genvar k = 0; k < NSt; k++) begin : g_en
    assign en[k] = out_o.ready || !(&vld_q[NSt-1:k]);
  end

  assign in_i.ready = en[StMul];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NSt; k++) begin
        if (en[k]) begin
          vld_q[k] <= vin[k];
        end
      end
    end
  end

  // Multiply stage
  cmn_t          mul_cmn_q;
  logic [W2-1:0] pa_q, pb_q;
  logic [C-1:0]  sw_q, sh_q;
  logic          hf_q;
  logic [W2-1:0] pa_d, pb_d;

  assign pa_d = W2'(in_i.src_h) * W2'(in_i.target_w);
  assign pb_d = W2'(in_i.target_h) * W2'(in_i.src_w);

  always_ff @(posedge clk_i) begin
    if (en[StMul]) begin
      mul_cmn_q.tx  <= in_i.target_x;
      mul_cmn_q.ty  <= in_i.target_y;
      mul_cmn_q.tw  <= in_i.target_w;
      mul_cmn_q.th  <= in_i.target_h;
      mul_cmn_q.deg <= (in_i.src_w == '0) || (in_i.src_h == '0);
      pa_q          <= pa_d;
      pb_q          <= pb_d;
      sw_q          <= in_i.src_w;
      sh_q          <= in_i.src_h;
      hf_q          <= in_i.horizontal_first;
    end
  end

  // Compare/select stage
  dv_t  sel_q;
  dv_t  sel_d;
  logic uw;

  always_comb begin
    uw         = hf_q ? (pa_q <= pb_q) : (pa_q < pb_q);
    sel_d.cmn  = mul_cmn_q;
    sel_d.uw   = uw;
    sel_d.d    = uw ? sw_q : sh_q;
    sel_d.work = uw ? pa_q : pb_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[StSel]) begin
      sel_q <= sel_d;
    end
  end

  // Division stages
  dv_t div_q [C];

  for (genvar k = 0; k < C; k++) begin : g_div
    dv_t src;
    dv_t nxt;
    if (k == 0) begin : g_first
      assign src = sel_q;
    end else begin : g_next
      assign src = div_q[k-1];
    end
    always_comb begin
      nxt      = src;
      nxt.work = div_step(src.work, src.d);
    end
    always_ff @(posedge clk_i) begin
      if (en[StDiv0+k]) begin
        div_q[k] <= nxt;
      end
    end
  end

  // Centring and output register
  dv_t          fin;
  logic [C-1:0] quo, fw, fh, dx, dy;
  logic [C:0]   ox_d, oy_d;
  logic [C:0]   out_x_q, out_y_q;
  logic [C-1:0] out_w_q, out_h_q;
  logic         deg_q;

  always_comb begin
    fin  = div_q[C-1];
    quo  = fin.work[C-1:0];
    fw   = fin.cmn.deg ? '0 : (fin.uw ? fin.cmn.tw : quo);
    fh   = fin.cmn.deg ? '0 : (fin.uw ? quo : fin.cmn.th);
    dx   = fin.cmn.tw - fw;
    dy   = fin.cmn.th - fh;
    ox_d = {fin.cmn.tx[C-1], fin.cmn.tx} + {2'b00, dx[C-1:1]};
    oy_d = {fin.cmn.ty[C-1], fin.cmn.ty} + {2'b00, dy[C-1:1]};
  end

  always_ff @(posedge clk_i) begin
    if (en[StOut]) begin
      out_x_q <= ox_d;
      out_y_q <= oy_d;
      out_w_q <= fw;
      out_h_q <= fh;
      deg_q   <= fin.cmn.deg;
    end
  end

  assign out_o.valid      = vld_q[StOut];
  assign out_o.out_x      = out_x_q;
  assign out_o.out_y      = out_y_q;
  assign out_o.out_w      = out_w_q;
  assign out_o.out_h      = out_h_q;
  assign out_o.degenerate = deg_q;

  // Assertions
  a_deg_zero_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.degenerate |-> out_o.out_w == '0 && out_o.out_h == '0)
    else $error("degenerate result with non-zero size");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&vld_q) && !out_o.ready |-> !in_i.ready)
    else $error("input accepted while pipeline full and stalled");

  a_sel_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[StSel] && !sel_q.cmn.deg |-> sel_q.work[W2-1:C] < sel_q.d)
    else $error("quotient would overflow the coordinate width");

  for (genvar k = 0; k < C; k++) begin : g_chk
    a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
      vld_q[StDiv0+k] && !div_q[k].cmn.deg |-> div_q[k].work[W2-1:C] < div_q[k].d)
      else $error("division remainder not below divisor");
  end

endmodule
